FILE: rtl/gf2_128_field_alu_macros.svh
// Assertion macros shared by the GF(2^128) field ALU RTL.
`ifndef GF2_128_FIELD_ALU_MACROS_SVH
`define GF2_128_FIELD_ALU_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define GF2M_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gf2m same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define GF2M_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gf2m next-cycle check failed");

`endif

FILE: rtl/gf2m_pkg.sv
// Shared types and constants for the GF(2^128) field ALU.
package gf2m_pkg;

    localparam int WORD_W  = 64;
    localparam int ELEM_W  = 2 * WORD_W;
    localparam int PROD_W  = 2 * WORD_W;

    // Shift amounts used when folding the top word back in
    localparam int FOLD_SH7 = 57;
    localparam int FOLD_SH2 = 62;
    localparam int FOLD_SH1 = 63;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_SQR = 2'd2
    } gf2m_op_t;

    // Stage 1: captured operation and operands (b replaced by a for square)
    typedef struct packed {
        gf2m_op_t          op;
        logic [WORD_W-1:0] a_lo;
        logic [WORD_W-1:0] a_hi;
        logic [WORD_W-1:0] b_lo;
        logic [WORD_W-1:0] b_hi;
    } gf2m_s1_t;

    // Stage 2: XOR sum and the four partial carry-less products
    typedef struct packed {
        gf2m_op_t          op;
        logic [ELEM_W-1:0] sum;
        logic [PROD_W-1:0] p_ll;
        logic [PROD_W-1:0] p_lh;
        logic [PROD_W-1:0] p_hl;
        logic [PROD_W-1:0] p_hh;
    } gf2m_s2_t;

endpackage

FILE: rtl/gf2_128_field_alu.sv
// Top level of the pipelined GF(2^128) field ALU.
//
// Adds, multiplies or squares elements of GF(2^128) in polynomial basis
// (reduction polynomial x^128 + x^7 + x^2 + x + 1, bit i = coefficient of
// x^i). Operation 0 is XOR, 1 is the reduced product a*b, 2 is the reduced
// square of a (b ignored); the unused code 3 returns zero. The datapath is a
// three-stage pipeline: operand capture, four parallel 64x64 carry-less
// multipliers, then partial-product combine and reduction into the output
// register. It accepts one item per cycle when out_ready is held high; the
// stage holding the carry-less multipliers sets the clock rate. Backpressure
// stalls each stage only when the stage after it is full, so no item is lost
// or repeated.
`include "gf2_128_field_alu_macros.svh"

module gf2_128_field_alu
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [gf2m_pkg::WORD_W-1:0] a_low,
    input  logic [gf2m_pkg::WORD_W-1:0] a_high,
    input  logic [gf2m_pkg::WORD_W-1:0] b_low,
    input  logic [gf2m_pkg::WORD_W-1:0] b_high,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gf2m_pkg::WORD_W-1:0] result_low,
    output logic [gf2m_pkg::WORD_W-1:0] result_high
);
    import gf2m_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    gf2m_s1_t          s1_reg, s1_next;
    gf2m_s2_t          s2_reg, s2_next;
    logic [ELEM_W-1:0] res_reg, res_next;
    logic              en1, en2, en3;
    gf2m_op_t          op_in;
    logic [ELEM_W-1:0] reduced;
    logic [WORD_W-1:0] w0, w1, w2, w3;

    // Stage enables: a stage loads when it is empty or its item moves on
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: capture operands; square feeds a to both multiplier inputs
    assign op_in = gf2m_op_t'(operation);

    always_comb
    begin
        s1_next.op   = op_in;
        s1_next.a_lo = a_low;
        s1_next.a_hi = a_high;
        if (op_in == OP_SQR)
        begin
            s1_next.b_lo = a_low;
            s1_next.b_hi = a_high;
        end
        else
        begin
            s1_next.b_lo = b_low;
            s1_next.b_hi = b_high;
        end
    end

    // Stage 2: four partial carry-less products and the XOR sum
    gf2m_clmul64 u_mul_ll (.x(s1_reg.a_lo), .y(s1_reg.b_lo), .p(s2_next.p_ll));
    gf2m_clmul64 u_mul_lh (.x(s1_reg.a_lo), .y(s1_reg.b_hi), .p(s2_next.p_lh));
    gf2m_clmul64 u_mul_hl (.x(s1_reg.a_hi), .y(s1_reg.b_lo), .p(s2_next.p_hl));
    gf2m_clmul64 u_mul_hh (.x(s1_reg.a_hi), .y(s1_reg.b_hi), .p(s2_next.p_hh));

    assign s2_next.op  = s1_reg.op;
    assign s2_next.sum = {s1_reg.a_hi ^ s1_reg.b_hi, s1_reg.a_lo ^ s1_reg.b_lo};

    // Stage 3: combine partial products into 256 bits, reduce, select
    assign w0 = s2_reg.p_ll[WORD_W-1:0];
    assign w1 = s2_reg.p_ll[PROD_W-1:WORD_W] ^ s2_reg.p_lh[WORD_W-1:0]
              ^ s2_reg.p_hl[WORD_W-1:0];
    assign w2 = s2_reg.p_hh[WORD_W-1:0] ^ s2_reg.p_lh[PROD_W-1:WORD_W]
              ^ s2_reg.p_hl[PROD_W-1:WORD_W];
    assign w3 = s2_reg.p_hh[PROD_W-1:WORD_W];

    gf2m_reduce u_reduce (.w0(w0), .w1(w1), .w2(w2), .w3(w3), .r(reduced));

    always_comb
    begin
        case (s2_reg.op)
            OP_ADD:  res_next = s2_reg.sum;
            OP_MUL:  res_next = reduced;
            OP_SQR:  res_next = reduced;
            default: res_next = '0;
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (en2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (en3 && v2_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = v3_reg;
    assign result_low  = res_reg[WORD_W-1:0];
    assign result_high = res_reg[ELEM_W-1:WORD_W];

    // A stalled stage-1 item stays put
    `GF2M_ASSERT_NEXT(a_s1_hold, v1_reg && !en2, v1_reg && $stable(s1_reg))
    // Squares reach stage 2 with matching cross products
    `GF2M_ASSERT_NOW(a_sqr_cross, v2_reg && s2_reg.op == OP_SQR, s2_reg.p_lh == s2_reg.p_hl)
    // An item leaving stage 2 shows up at the output next cycle
    `GF2M_ASSERT_NEXT(a_s2_to_out, en3 && v2_reg, out_valid)

endmodule

FILE: rtl/gf2m_clmul64.sv
// Carry-less 64x64 -> 128-bit multiplier (XOR tree of shifted partial products).
module gf2m_clmul64
(
    input  logic [gf2m_pkg::WORD_W-1:0] x,
    input  logic [gf2m_pkg::WORD_W-1:0] y,
    output logic [gf2m_pkg::PROD_W-1:0] p
);
    import gf2m_pkg::*;

    // One shifted copy of x per set bit of y
    always_comb
    begin
        logic [PROD_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (y[i])
            begin
                acc = acc ^ ({{(PROD_W-WORD_W){1'b0}}, x} << i);
            end
        end
        p = acc;
    end

endmodule

FILE: rtl/gf2m_reduce.sv
// Reduction of a 256-bit product modulo x^128 + x^7 + x^2 + x + 1.
module gf2m_reduce
(
    input  logic [gf2m_pkg::WORD_W-1:0] w0,
    input  logic [gf2m_pkg::WORD_W-1:0] w1,
    input  logic [gf2m_pkg::WORD_W-1:0] w2,
    input  logic [gf2m_pkg::WORD_W-1:0] w3,
    output logic [gf2m_pkg::ELEM_W-1:0] r
);
    import gf2m_pkg::*;

    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] h;
    logic [WORD_W-1:0] l;

    // Fold the top word into words 2 and 1, then fold the new word 2 into words 1..0
    assign t = w2 ^ (w3 >> FOLD_SH7) ^ (w3 >> FOLD_SH2) ^ (w3 >> FOLD_SH1);
    assign h = w1 ^ w3
             ^ ((w3 << 7) | (t >> FOLD_SH7))
             ^ ((w3 << 2) | (t >> FOLD_SH2))
             ^ ((w3 << 1) | (t >> FOLD_SH1));
    assign l = w0 ^ t ^ (t << 7) ^ (t << 2) ^ (t << 1);
    assign r = {h, l};

endmodule
